// ----- sv/dtcm_pkg.sv -----
// dtcm_pkg: shared types and constants for the trouble code manager.
// No dependencies.
`timescale 1ns / 1ps
package dtcm_pkg;
	localparam logic [2:0] MODE_REPORT  = 3'd0;
	localparam logic [2:0] MODE_COUNT   = 3'd1;
	localparam logic [2:0] MODE_LIST    = 3'd2;
	localparam logic [2:0] MODE_IDS     = 3'd3;
	localparam logic [2:0] MODE_RECORDS = 3'd4;
	localparam logic [2:0] MODE_VOLTAGE = 3'd5;
	localparam logic [2:0] MODE_SUPP    = 3'd6;
	localparam logic [2:0] MODE_CLEAR   = 3'd7;

	localparam logic [7:0] ST_FAILED       = 8'h01;
	localparam logic [7:0] ST_FAILED_CYCLE = 8'h02;
	localparam logic [7:0] ST_PENDING      = 8'h04;
	localparam logic [7:0] ST_CONFIRMED    = 8'h08;
	localparam logic [7:0] ST_FAILED_SLC   = 8'h20;
	localparam logic [7:0] REC_ALL         = 8'hFF;
	localparam logic [7:0] RUN_MAX         = 8'hFF;
	localparam logic [3:0] MAX_RESULTS     = 4'd12;

	localparam logic [7:0] CONFIRM_RESET = 8'd2;
	localparam logic [7:0] HEAL_RESET    = 8'd3;
	localparam logic       REG_CONFIRM   = 1'b0;
	localparam logic       REG_HEAL      = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] trouble_code;
		logic        fault_active;
		logic [15:0] supply_millivolts;
		logic [7:0]  status_mask;
		logic [7:0]  wanted_record;
		logic [2:0]  request_length;
		logic [7:0]  response_room;
		logic        reject;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        has_entry;
		logic [2:0]  match_count;
		logic [23:0] entry_code;
		logic [7:0]  entry_status;
		logic [1:0]  entry_record;
		logic [15:0] entry_millivolts;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_FIND, BK_RUN, BK_EMIT, BK_DONE
	} bk_state_t;
endpackage

// ----- sv/dtcm_front.sv -----
// dtcm_front: input word capture, early rejection by length and room, and a
// two-deep request queue. Depends on dtcm_pkg.
`timescale 1ns / 1ps
module dtcm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [71:0]    s_tdata,
	input  logic           q_pop,
	output logic           q_valid,
	output dtcm_pkg::req_t q_head
);
	import dtcm_pkg::*;

	req_t r;
	req_t fifo_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	always_comb begin
		r.mode              = s_tdata[2:0];
		r.trouble_code      = s_tdata[26:3];
		r.fault_active      = s_tdata[27];
		r.supply_millivolts = s_tdata[43:28];
		r.status_mask       = s_tdata[51:44];
		r.wanted_record     = s_tdata[59:52];
		r.request_length    = s_tdata[62:60];
		r.response_room     = s_tdata[70:63];
		case (r.mode)
			MODE_COUNT:   r.reject = r.request_length < 3'd1 || r.response_room < 8'd6;
			MODE_LIST:    r.reject = r.request_length < 3'd1 || r.response_room < 8'd2;
			MODE_IDS,
			MODE_SUPP:    r.reject = r.response_room < 8'd1;
			MODE_RECORDS: r.reject = r.request_length < 3'd4 || r.response_room < 8'd5;
			MODE_VOLTAGE: r.reject = r.request_length < 3'd4 || r.response_room < 8'd10;
			default:      r.reject = 1'b0;
		endcase
	end

	assign s_tready = cnt_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_head   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push || q_pop) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ----- sv/dtcm_back.sv -----
// dtcm_back: the trouble code table, snapshot slots and the sequencer that
// serves one request at a time. Depends on dtcm_pkg.
`timescale 1ns / 1ps
module dtcm_back #(
	parameter int TABLE_ENTRIES  = 4,
	parameter int SNAPSHOT_SLOTS = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  dtcm_pkg::req_t q_head,
	output logic           q_pop,
	input  logic [7:0]     confirm_threshold,
	input  logic [7:0]     heal_threshold,
	output logic           m_tvalid,
	input  logic           m_tready,
	output dtcm_pkg::res_t m_res
);
	import dtcm_pkg::*;

	localparam int EW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int SW = $clog2(SNAPSHOT_SLOTS + 1);
	localparam int NSLOT = TABLE_ENTRIES * SNAPSHOT_SLOTS;
	localparam int KW = NSLOT > 1 ? $clog2(NSLOT) : 1;

	logic [23:0] code_q   [TABLE_ENTRIES];
	logic [7:0]  status_q [TABLE_ENTRIES];
	logic [7:0]  fail_q   [TABLE_ENTRIES];
	logic [7:0]  pass_q   [TABLE_ENTRIES];
	logic [15:0] volt_q   [NSLOT];
	logic [NSLOT-1:0] sv_q;
	logic [UW-1:0] used_q;

	bk_state_t state_q, state_d;
	req_t req_q;
	logic [UW-1:0] i_q;
	logic [SW-1:0] s_q;
	logic [8:0]  off_q;
	logic [3:0]  n_q;
	logic [2:0]  cnt_q;
	logic        found_q;
	logic [EW-1:0] e_q;
	res_t res_q;
	logic have_q;     // a result is held back for the last flag
	logic out_v_q;

	logic [EW-1:0] ie;
	logic [KW-1:0] k_cur;
	logic out_free;
	res_t pend;
	logic pend_v, fin, fin_empty;
	logic [7:0] st_cur;

	assign ie     = i_q[EW-1:0];
	assign k_cur  = KW'(ie * SNAPSHOT_SLOTS + s_q);
	assign st_cur = status_q[ie];
	assign out_free = !out_v_q || m_tready;
	assign m_tvalid = out_v_q;
	assign q_pop = state_q == BK_IDLE && q_valid && out_free && !have_q;

	// next values to be written for the report step
	logic [7:0] f_nx, p_nx, s_nx;
	logic [7:0] st_base, f_base, p_base;
	logic new_e;
	logic [SNAPSHOT_SLOTS-1:0] free_v;
	logic [SNAPSHOT_SLOTS-1:0] take_v;
	always_comb begin
		new_e  = !found_q;
		st_base = new_e ? 8'd0 : status_q[e_q];
		f_base  = new_e ? 8'd0 : fail_q[e_q];
		p_base  = new_e ? 8'd0 : pass_q[e_q];
		f_nx = f_base; p_nx = p_base; s_nx = st_base;
		if (req_q.fault_active) begin
			p_nx = 8'd0;
			f_nx = f_base == RUN_MAX ? f_base : f_base + 8'd1;
			s_nx = st_base | ST_FAILED | ST_FAILED_CYCLE | ST_PENDING | ST_FAILED_SLC;
			if (f_nx >= confirm_threshold)
				s_nx = s_nx | ST_CONFIRMED;
		end else begin
			f_nx = 8'd0;
			p_nx = p_base == RUN_MAX ? p_base : p_base + 8'd1;
			s_nx = st_base & ~ST_FAILED;
			if (p_nx >= heal_threshold) begin
				s_nx = s_nx & ~(ST_PENDING | ST_CONFIRMED);
				p_nx = 8'd0;
			end
		end
		for (int s = 0; s < SNAPSHOT_SLOTS; s++)
			free_v[s] = new_e || !sv_q[KW'(e_q * SNAPSHOT_SLOTS + s)];
		// first free slot takes the voltage on a failure
		for (int s = 0; s < SNAPSHOT_SLOTS; s++)
			take_v[s] = req_q.fault_active && free_v[s] &&
				!(|(free_v & SNAPSHOT_SLOTS'((1 << s) - 1)));
	end

	// sequencer
	logic step_i, step_s, do_report, do_clear, emit_now, lastflag;
	res_t emit_r;
	always_comb begin
		state_d = state_q;
		step_i = 1'b0; step_s = 1'b0; do_report = 1'b0; do_clear = 1'b0;
		emit_now = 1'b0; lastflag = 1'b0; fin = 1'b0; fin_empty = 1'b0;
		emit_r = '0;
		emit_r.accepted = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (q_pop)
					state_d = q_head.reject ? BK_DONE : BK_FIND;
			end
			BK_FIND: begin
				// linear search for the code where the mode needs it
				if (req_q.mode == MODE_REPORT || req_q.mode == MODE_RECORDS ||
						req_q.mode == MODE_VOLTAGE) begin
					if (i_q < used_q && !found_q) begin
						step_i = 1'b1;
					end else begin
						state_d = BK_RUN;
					end
				end else if (req_q.mode == MODE_CLEAR) begin
					do_clear = 1'b1;
					state_d = BK_DONE;
				end else begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				case (req_q.mode)
					MODE_REPORT: begin
						if (!found_q && used_q >= UW'(TABLE_ENTRIES)) begin
							state_d = BK_DONE;
						end else if (out_free) begin
							do_report = 1'b1;
							state_d = BK_IDLE;
						end
					end
					MODE_COUNT: begin
						if (i_q < used_q)
							step_i = 1'b1;
						else if (out_free)
							state_d = BK_IDLE;
					end
					MODE_LIST, MODE_SUPP: begin
						if (i_q < used_q && n_q < MAX_RESULTS) begin
							if (req_q.mode == MODE_LIST && (st_cur & req_q.status_mask) == 8'd0)
								step_i = 1'b1;
							else if (off_q + 9'd4 > {1'b0, req_q.response_room})
								fin = 1'b1;
							else if (out_free) begin
								emit_now = 1'b1;
								emit_r.has_entry = 1'b1;
								emit_r.entry_code = code_q[ie];
								emit_r.entry_status = st_cur;
								step_i = 1'b1;
							end
						end else
							fin = 1'b1;
					end
					MODE_IDS: begin
						if (i_q < used_q) begin
							if (!sv_q[k_cur])
								step_s = 1'b1;
							else if (off_q + 9'd4 > {1'b0, req_q.response_room} ||
									n_q >= MAX_RESULTS)
								fin = 1'b1;
							else if (out_free) begin
								emit_now = 1'b1;
								emit_r.has_entry = 1'b1;
								emit_r.entry_code = code_q[ie];
								emit_r.entry_record = 2'(s_q + 1'b1);
								step_s = 1'b1;
							end
						end else
							fin = 1'b1;
					end
					default: begin // records and voltage
						if (!found_q)
							state_d = BK_DONE;
						else if (s_q <= SW'(SNAPSHOT_SLOTS - 1) &&
								{1'b0, s_q} < (SW+1)'(SNAPSHOT_SLOTS) && n_q < MAX_RESULTS) begin
							if (!sv_q[KW'(e_q * SNAPSHOT_SLOTS + s_q)] ||
									(req_q.wanted_record != REC_ALL &&
									req_q.wanted_record != 8'(s_q + 1'b1)))
								step_s = 1'b1;
							else if (req_q.mode == MODE_VOLTAGE) begin
								if (out_free) begin
									emit_now = 1'b1;
									lastflag = 1'b1;
									emit_r.has_entry = 1'b1;
									emit_r.entry_code = req_q.trouble_code;
									emit_r.entry_status = status_q[e_q];
									emit_r.entry_record = 2'(s_q + 1'b1);
									emit_r.entry_millivolts =
										volt_q[KW'(e_q * SNAPSHOT_SLOTS + s_q)];
									state_d = BK_IDLE;
								end
							end else if (off_q + 9'd5 > {1'b0, req_q.response_room})
								fin = 1'b1;
							else if (out_free) begin
								emit_now = 1'b1;
								emit_r.has_entry = 1'b1;
								emit_r.entry_code = req_q.trouble_code;
								emit_r.entry_status = status_q[e_q];
								emit_r.entry_record = 2'(s_q + 1'b1);
								step_s = 1'b1;
							end
						end else if (req_q.mode == MODE_VOLTAGE)
							state_d = BK_DONE;
						else
							fin = 1'b1;
					end
				endcase
				if (fin) begin
					if (have_q) begin
						if (out_free)
							state_d = BK_IDLE;
					end else begin
						fin_empty = 1'b1;
						if (out_free)
							state_d = BK_IDLE;
					end
				end
			end
			BK_DONE: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// output staging: entries are held one word back so the final one carries last
	always_comb begin
		pend = '0;
		pend_v = 1'b0;
		if (state_q == BK_RUN && out_free) begin
			if (req_q.mode == MODE_REPORT && do_report) begin
				pend_v = 1'b1;
				pend.accepted = 1'b1;
				pend.has_entry = 1'b1;
				pend.entry_code = req_q.trouble_code;
				pend.entry_status = s_nx;
				pend.last = 1'b1;
			end else if (req_q.mode == MODE_COUNT && i_q >= used_q) begin
				pend_v = 1'b1;
				pend.accepted = 1'b1;
				pend.match_count = cnt_q;
				pend.last = 1'b1;
			end else if (emit_now && have_q) begin
				pend_v = 1'b1;
				pend = res_q;
			end else if (emit_now && lastflag) begin
				pend_v = 1'b1;
				pend = emit_r;
				pend.last = 1'b1;
			end else if (fin) begin
				pend_v = 1'b1;
				if (fin_empty) begin
					pend.accepted = 1'b1;
				end else
					pend = res_q;
				pend.last = 1'b1;
			end
		end else if (state_q == BK_DONE && out_free) begin
			pend_v = 1'b1;
			pend.accepted = req_q.mode == MODE_CLEAR;
			pend.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			req_q <= q_head;
		if (emit_now && !lastflag)
			res_q <= emit_r;
		if (pend_v)
			m_res <= pend;
		if (do_report) begin
			code_q[e_q]   <= req_q.trouble_code;
			status_q[e_q] <= s_nx;
			fail_q[e_q]   <= f_nx;
			pass_q[e_q]   <= p_nx;
			for (int s = 0; s < SNAPSHOT_SLOTS; s++) begin
				if (take_v[s])
					volt_q[KW'(e_q * SNAPSHOT_SLOTS + s)] <= req_q.supply_millivolts;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			used_q  <= '0;
			sv_q    <= '0;
			i_q     <= '0;
			s_q     <= '0;
			off_q   <= 9'd1;
			n_q     <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			e_q     <= '0;
			have_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pend_v)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			if (q_pop) begin
				i_q <= '0; s_q <= '0; n_q <= '0; cnt_q <= '0;
				found_q <= 1'b0; e_q <= '0; have_q <= 1'b0;
				off_q <= (q_head.mode == MODE_RECORDS || q_head.mode == MODE_VOLTAGE) ?
					9'd0 : 9'd1;
			end
			if (state_q == BK_FIND && step_i) begin
				if (code_q[ie] == req_q.trouble_code) begin
					found_q <= 1'b1;
					e_q <= ie;
				end else
					i_q <= i_q + 1'b1;
			end
			if (state_q == BK_FIND && state_d == BK_RUN) begin
				if (req_q.mode == MODE_REPORT && !(i_q < used_q && !found_q) && !found_q)
					e_q <= used_q[EW-1:0];
				i_q <= '0;
			end
			if (state_q == BK_RUN && step_i) begin
				i_q <= i_q + 1'b1;
				if (req_q.mode == MODE_COUNT && (st_cur & req_q.status_mask) != 8'd0)
					cnt_q <= cnt_q + 3'd1;
			end
			if (step_s) begin
				if (req_q.mode == MODE_IDS && s_q == SW'(SNAPSHOT_SLOTS - 1)) begin
					s_q <= '0;
					i_q <= i_q + 1'b1;
				end else
					s_q <= s_q + 1'b1;
			end
			if (emit_now && !lastflag) begin
				have_q <= 1'b1;
				n_q <= n_q + 4'd1;
				off_q <= off_q + ((req_q.mode == MODE_RECORDS) ? 9'd5 : 9'd4);
			end
			if (fin && out_free)
				have_q <= 1'b0;
			if (do_report) begin
				if (!found_q)
					used_q <= used_q + 1'b1;
				// a new entry starts with every slot empty but the one that takes the voltage
				for (int s = 0; s < SNAPSHOT_SLOTS; s++) begin
					if (take_v[s])
						sv_q[KW'(e_q * SNAPSHOT_SLOTS + s)] <= 1'b1;
					else if (!found_q)
						sv_q[KW'(e_q * SNAPSHOT_SLOTS + s)] <= 1'b0;
				end
			end
			if (do_clear) begin
				used_q <= '0;
				sv_q   <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_ENTRIES)) else $error("table overfilled");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_RESULTS) else $error("result cap exceeded");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready |=> $stable(m_res)) else $error("output overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == BK_IDLE && !have_q) else $error("pop while busy");
`endif
endmodule

// ----- sv/diagnostic_trouble_code_manager_top.sv -----
// Serves test reports and queries on a small trouble code table; a request
// is queued in the front end and then served by the sequential scan of table
// entries or snapshot slots in the back end. Depends on dtcm_pkg, dtcm_front
// and dtcm_back.
`timescale 1ns / 1ps
module diagnostic_trouble_code_manager_top #(
	parameter int TABLE_ENTRIES  = 4,
	parameter int SNAPSHOT_SLOTS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode, trouble_code, fault_active, supply_millivolts, status_mask,
	// wanted_record, request_length, response_room
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted, has_entry, match_count, entry_code, entry_status,
	// entry_record, entry_millivolts
	output logic [55:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dtcm_pkg::*;

	logic [7:0] confirm_q, heal_q;
	logic q_valid, q_pop;
	req_t q_head;
	res_t res;

	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_CONFIRM: prdata = {24'd0, confirm_q};
			REG_HEAL:    prdata = {24'd0, heal_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= CONFIRM_RESET;
			heal_q    <= HEAL_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_CONFIRM)
				confirm_q <= pwdata[7:0];
			else
				heal_q <= pwdata[7:0];
		end
	end

	dtcm_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_pop, .q_valid, .q_head
	);

	dtcm_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .SNAPSHOT_SLOTS(SNAPSHOT_SLOTS)) u_back (
		.clk, .arst_n, .q_valid, .q_head, .q_pop,
		.confirm_threshold(confirm_q), .heal_threshold(heal_q),
		.m_tvalid, .m_tready, .m_res(res)
	);

	assign m_tdata = {1'b0, res.entry_millivolts, res.entry_record, res.entry_status,
		res.entry_code, res.match_count, res.has_entry, res.accepted};
	assign m_tlast = res.last;
endmodule

// ----- tb/dtc_table_checker.sv -----
// Checker for the trouble code manager: tracks the register writes and the
// request words, predicts the result words and compares them as they leave.
// Depends on dtcm_pkg.
`timescale 1ns / 1ps
module dtc_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          outstanding
);
	import dtcm_pkg::*;

	logic [7:0]  confirm_at;
	logic [7:0]  heal_at;
	int          used;
	logic [23:0] code_tab [4];
	logic [7:0]  stat_tab [4];
	logic [7:0]  fail_cnt [4];
	logic [7:0]  pass_cnt [4];
	bit          frame_ok [12];
	logic [15:0] frame_mv [12];
	res_t        owed_words[$];
	res_t        burst[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic int find_code(logic [23:0] c);
		for (int i = 0; i < used; i++)
			if (code_tab[i] == c)
				return i;
		return -1;
	endfunction

	task automatic post(logic acc, logic has, logic [2:0] cnt, logic [23:0] code,
		logic [7:0] st, logic [1:0] rec, logic [15:0] mv);
		res_t r;
		r = '0;
		r.accepted = acc;
		r.has_entry = has;
		r.match_count = cnt;
		r.entry_code = code;
		r.entry_status = st;
		r.entry_record = rec;
		r.entry_millivolts = mv;
		burst.push_back(r);
	endtask

	task automatic close_burst();
		if (burst.size() == 0)
			post(1'b1, 1'b0, 3'd0, 24'd0, 8'd0, 2'd0, 16'd0);
		burst[burst.size() - 1].last = 1'b1;
		foreach (burst[k])
			owed_words.push_back(burst[k]);
		burst.delete();
	endtask

	task automatic refuse();
		burst.delete();
		post(1'b0, 1'b0, 3'd0, 24'd0, 8'd0, 2'd0, 16'd0);
		close_burst();
	endtask

	task automatic apply_request(logic [71:0] w);
		logic [2:0]  mode;
		logic [23:0] code;
		logic        fault;
		logic [15:0] mv;
		logic [7:0]  mask;
		logic [7:0]  want;
		logic [2:0]  rlen;
		logic [7:0]  room;
		int          e;
		int          off;
		int          cnt;
		bit          stop;
		mode = w[2:0];
		code = w[26:3];
		fault = w[27];
		mv = w[43:28];
		mask = w[51:44];
		want = w[59:52];
		rlen = w[62:60];
		room = w[70:63];
		off = 1;
		stop = 0;
		burst.delete();
		case (mode)
			MODE_REPORT: begin
				e = find_code(code);
				if (e < 0 && used >= 4) begin
					refuse();
					return;
				end
				if (e < 0) begin
					e = used++;
					code_tab[e] = code;
					stat_tab[e] = 0;
					fail_cnt[e] = 0;
					pass_cnt[e] = 0;
					for (int s = 0; s < 3; s++)
						frame_ok[e*3 + s] = 0;
				end
				if (fault) begin
					pass_cnt[e] = 0;
					if (fail_cnt[e] != RUN_MAX)
						fail_cnt[e]++;
					stat_tab[e] |= ST_FAILED | ST_FAILED_CYCLE | ST_PENDING | ST_FAILED_SLC;
					if (fail_cnt[e] >= confirm_at)
						stat_tab[e] |= ST_CONFIRMED;
					for (int s = 0; s < 3 && !stop; s++)
						if (!frame_ok[e*3 + s]) begin
							frame_ok[e*3 + s] = 1;
							frame_mv[e*3 + s] = mv;
							stop = 1;
						end
				end else begin
					fail_cnt[e] = 0;
					if (pass_cnt[e] != RUN_MAX)
						pass_cnt[e]++;
					stat_tab[e] &= ~ST_FAILED;
					if (pass_cnt[e] >= heal_at) begin
						stat_tab[e] &= ~(ST_PENDING | ST_CONFIRMED);
						pass_cnt[e] = 0;
					end
				end
				post(1'b1, 1'b1, 3'd0, code, stat_tab[e], 2'd0, 16'd0);
				close_burst();
			end
			MODE_COUNT: begin
				if (rlen < 1 || room < 6) begin
					refuse();
					return;
				end
				cnt = 0;
				for (int i = 0; i < used; i++)
					if ((stat_tab[i] & mask) != 0)
						cnt++;
				post(1'b1, 1'b0, cnt[2:0], 24'd0, 8'd0, 2'd0, 16'd0);
				close_burst();
			end
			MODE_LIST, MODE_SUPP: begin
				if ((mode == MODE_LIST && rlen < 1) || room < (mode == MODE_LIST ? 2 : 1)) begin
					refuse();
					return;
				end
				for (int i = 0; i < used && burst.size() < MAX_RESULTS; i++) begin
					if (mode == MODE_LIST && (stat_tab[i] & mask) == 0)
						continue;
					if (off + 4 > room)
						break;
					off += 4;
					post(1'b1, 1'b1, 3'd0, code_tab[i], stat_tab[i], 2'd0, 16'd0);
				end
				close_burst();
			end
			MODE_IDS: begin
				if (room < 1) begin
					refuse();
					return;
				end
				for (int i = 0; i < used; i++)
					for (int s = 0; s < 3; s++)
						if (!stop && frame_ok[i*3 + s]) begin
							if (off + 4 > room || burst.size() >= MAX_RESULTS)
								stop = 1;
							else begin
								off += 4;
								post(1'b1, 1'b1, 3'd0, code_tab[i], 8'd0, 2'(s + 1), 16'd0);
							end
						end
				close_burst();
			end
			MODE_RECORDS, MODE_VOLTAGE: begin
				e = find_code(code);
				if (rlen < 4 || room < (mode == MODE_RECORDS ? 5 : 10) || e < 0) begin
					refuse();
					return;
				end
				off = 0;
				for (int s = 0; s < 3 && !stop; s++) begin
					if (!frame_ok[e*3 + s] || (want != REC_ALL && want != s + 1))
						continue;
					if (mode == MODE_VOLTAGE) begin
						post(1'b1, 1'b1, 3'd0, code, stat_tab[e], 2'(s + 1), frame_mv[e*3 + s]);
						stop = 1;
					end else if (off + 5 > room)
						stop = 1;
					else begin
						off += 5;
						post(1'b1, 1'b1, 3'd0, code, stat_tab[e], 2'(s + 1), 16'd0);
					end
				end
				if (mode == MODE_VOLTAGE && burst.size() == 0)
					refuse();
				else
					close_burst();
			end
			default: begin
				used = 0;
				foreach (frame_ok[k])
					frame_ok[k] = 0;
				post(1'b1, 1'b0, 3'd0, 24'd0, 8'd0, 2'd0, 16'd0);
				close_burst();
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want_word;
		if (!arst_n) begin
			confirm_at = CONFIRM_RESET;
			heal_at = HEAL_RESET;
			used = 0;
			foreach (frame_ok[k])
				frame_ok[k] = 0;
			owed_words.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_HEAL)
					heal_at = pwdata[7:0];
				else
					confirm_at = pwdata[7:0];
			end
			if (s_tvalid && s_tready)
				apply_request(s_tdata);
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.has_entry = m_tdata[1];
				got.match_count = m_tdata[4:2];
				got.entry_code = m_tdata[28:5];
				got.entry_status = m_tdata[36:29];
				got.entry_record = m_tdata[38:37];
				got.entry_millivolts = m_tdata[54:39];
				got.last = m_tlast;
				if (owed_words.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual %p", $time, got);
				end else begin
					want_word = owed_words.pop_front();
					if (got !== want_word) begin
						mismatches++;
						$display("%0t: word mismatch, expected %p, actual %p",
							$time, want_word, got);
					end
				end
			end
		end
		outstanding = owed_words.size();
	end
endmodule

// ----- tb/diagnostic_trouble_code_manager_top_test.sv -----
// Testbench top for the trouble code manager: clock, reset, register writes,
// request words and back-pressure; verdict from dtc_table_checker.
// Depends on dtcm_pkg, dtc_table_checker and the block itself.
`timescale 1ns / 1ps
module diagnostic_trouble_code_manager_top_test;
	import dtcm_pkg::*;

	localparam int LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          outstanding;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_len = 0;
	int          hold_left = 0;
	int          cycles = 0;
	logic [23:0] code_pool [6];

	diagnostic_trouble_code_manager_top u_dut (.*);

	dtc_table_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic offer(logic [2:0] mode, logic [23:0] code, logic fault, logic [15:0] mv,
		logic [7:0] mask, logic [7:0] want, logic [2:0] rlen, logic [7:0] room);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, room, rlen, want, mask, mv, fault, code, mode};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic sel, logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		logic [2:0]  mode;
		logic [23:0] code;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 50)
			mode = MODE_REPORT;
		else if (pick < 96)
			mode = 3'($urandom_range(MODE_COUNT, MODE_SUPP));
		else
			mode = MODE_CLEAR;
		code = ($urandom_range(9) == 0) ? 24'($urandom) : code_pool[$urandom_range(5)];
		offer(mode, code, 1'($urandom_range(2) != 0), 16'($urandom), 8'($urandom),
			($urandom_range(2) == 0) ? REC_ALL : 8'($urandom_range(4)),
			($urandom_range(3) == 0) ? 3'($urandom_range(4)) : 3'd4,
			($urandom_range(3) == 0) ? 8'($urandom_range(12)) : 8'($urandom));
	endtask

	initial begin
		code_pool = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'hA5A5A5, 24'h5A5A5A, 24'h00C0DE};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_CONFIRM, 8'd1);
		write_reg(REG_HEAL, 8'd1);

		// directed
		offer(MODE_COUNT, 24'd0, 1'b0, 16'd0, 8'hFF, 8'd0, 3'd1, 8'd6);
		offer(MODE_LIST, 24'd0, 1'b0, 16'd0, 8'hFF, 8'd0, 3'd1, 8'd255);
		offer(MODE_REPORT, 24'hFFFFFF, 1'b1, 16'hFFFF, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'hFFFFFF, 1'b1, 16'h0000, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'hFFFFFF, 1'b1, 16'h1234, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'hFFFFFF, 1'b1, 16'h4321, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'h000000, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'h123456, 1'b1, 16'hAAAA, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'h654321, 1'b1, 16'h5555, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_REPORT, 24'h777777, 1'b1, 16'h1111, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_COUNT, 24'd0, 1'b0, 16'd0, 8'h01, 8'd0, 3'd0, 8'd6);
		offer(MODE_COUNT, 24'd0, 1'b0, 16'd0, 8'h2F, 8'd0, 3'd1, 8'd5);
		offer(MODE_COUNT, 24'd0, 1'b0, 16'd0, 8'h00, 8'd0, 3'd4, 8'd255);
		offer(MODE_LIST, 24'd0, 1'b0, 16'd0, 8'h01, 8'd0, 3'd1, 8'd9);
		offer(MODE_LIST, 24'd0, 1'b0, 16'd0, 8'hFF, 8'd0, 3'd1, 8'd1);
		offer(MODE_IDS, 24'd0, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd0);
		offer(MODE_IDS, 24'd0, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd255);
		offer(MODE_IDS, 24'd0, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd8);
		offer(MODE_RECORDS, 24'hFFFFFF, 1'b0, 16'd0, 8'd0, REC_ALL, 3'd4, 8'd255);
		offer(MODE_RECORDS, 24'hFFFFFF, 1'b0, 16'd0, 8'd0, REC_ALL, 3'd3, 8'd255);
		offer(MODE_RECORDS, 24'hFFFFFF, 1'b0, 16'd0, 8'd0, 8'd2, 3'd4, 8'd5);
		offer(MODE_RECORDS, 24'hBADBAD, 1'b0, 16'd0, 8'd0, REC_ALL, 3'd4, 8'd255);
		offer(MODE_VOLTAGE, 24'hFFFFFF, 1'b0, 16'd0, 8'd0, 8'd3, 3'd4, 8'd10);
		offer(MODE_VOLTAGE, 24'h000000, 1'b0, 16'd0, 8'd0, REC_ALL, 3'd4, 8'd255);
		offer(MODE_SUPP, 24'd0, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd255);
		offer(MODE_CLEAR, 24'd0, 1'b0, 16'd0, 8'd0, 8'd0, 3'd0, 8'd0);
		drain();

		// random phases, one idling pattern and one register setting each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(REG_CONFIRM, 8'd255); write_reg(REG_HEAL, 8'd255); end
				1: begin write_reg(REG_CONFIRM, 8'd0); write_reg(REG_HEAL, 8'd0); end
				2: begin write_reg(REG_CONFIRM, 8'd3); write_reg(REG_HEAL, 8'd2); end
				default: begin write_reg(REG_CONFIRM, 8'd2); write_reg(REG_HEAL, 8'd1); end
			endcase
			send_idle_pct = (ph == 1 || ph == 3) ? 67 : 0;
			stall_pct = (ph == 2) ? 67 : (ph == 3) ? 37 : 0;
			if (ph == 3)
				send_idle_pct = 37;
			if (ph == 2)
				hold_len = 400;
			for (int n = 0; n < 55; n++) begin
				random_word();
				if (n == 27)
					drain();
			end
			drain();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/dtcm_pkg.sv
sv/dtcm_front.sv
sv/dtcm_back.sv
sv/diagnostic_trouble_code_manager_top.sv
tb/dtc_table_checker.sv
tb/diagnostic_trouble_code_manager_top_test.sv
